@@ src/byte_cpu_instruction_step_defines.svh @@
// Assertion macros shared by the byte CPU RTL.
`ifndef BYTE_CPU_INSTRUCTION_STEP_DEFINES_SVH
`define BYTE_CPU_INSTRUCTION_STEP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCIS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcis check failed");

// Next-cycle implication, checked outside reset.
`define BCIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcis check failed");

`endif

@@ src/bcis_pkg.sv @@
// Shared types and constants for the byte CPU.
package bcis_pkg;

    // Request opcodes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Result events
    localparam logic [2:0] EV_DONE    = 3'd0;
    localparam logic [2:0] EV_CHAR    = 3'd1;
    localparam logic [2:0] EV_EXIT    = 3'd2;
    localparam logic [2:0] EV_STACK   = 3'd3;
    localparam logic [2:0] EV_INVALID = 3'd4;
    localparam logic [2:0] EV_HALTED  = 3'd5;
    localparam logic [2:0] EV_NONE    = 3'd6;

    // Register indexes
    localparam logic [3:0] REG_SP = 4'hE;
    localparam logic [3:0] REG_PC = 4'hF;

    // Instruction opcodes
    localparam logic [7:0] I_MOV    = 8'h10;
    localparam logic [7:0] I_LD     = 8'h11;
    localparam logic [7:0] I_ST     = 8'h12;
    localparam logic [7:0] I_MCPY   = 8'h13;
    localparam logic [7:0] I_LI2    = 8'h14;
    localparam logic [7:0] I_ADDI   = 8'h15;
    localparam logic [7:0] I_SUBI   = 8'h16;
    localparam logic [7:0] I_PCADD  = 8'h17;
    localparam logic [7:0] I_PCSUB  = 8'h18;
    localparam logic [7:0] I_AND    = 8'h20;
    localparam logic [7:0] I_OR     = 8'h30;
    localparam logic [7:0] I_XOR    = 8'h40;
    localparam logic [7:0] I_SHL    = 8'h50;
    localparam logic [7:0] I_SHR    = 8'h51;
    localparam logic [7:0] I_ROL    = 8'h52;
    localparam logic [7:0] I_ROR    = 8'h53;
    localparam logic [7:0] I_JMP    = 8'h70;
    localparam logic [7:0] I_JLT    = 8'h71;
    localparam logic [7:0] I_JLE    = 8'h72;
    localparam logic [7:0] I_JEQ    = 8'h73;
    localparam logic [7:0] I_JGE    = 8'h74;
    localparam logic [7:0] I_JGT    = 8'h75;
    localparam logic [7:0] I_JNE    = 8'h76;
    localparam logic [7:0] I_SKNZ   = 8'h77;
    localparam logic [7:0] I_SKZ    = 8'h78;
    localparam logic [7:0] I_ADD    = 8'hA0;
    localparam logic [7:0] I_ADDM   = 8'hA1;
    localparam logic [7:0] I_ADDST  = 8'hA2;
    localparam logic [7:0] I_ADDK   = 8'hA3;
    localparam logic [7:0] I_MULK   = 8'hA4;
    localparam logic [7:0] I_SUMK   = 8'hA5;
    localparam logic [7:0] I_MACK   = 8'hA6;
    localparam logic [7:0] I_SUB    = 8'hA7;
    localparam logic [7:0] I_SUBM   = 8'hA8;
    localparam logic [7:0] I_RSUBM  = 8'hA9;
    localparam logic [7:0] I_SUBST  = 8'hAA;
    localparam logic [7:0] I_SUBK   = 8'hAB;
    localparam logic [7:0] I_RSUBK  = 8'hAC;
    localparam logic [7:0] I_CALL   = 8'hC2;
    localparam logic [7:0] I_RET    = 8'hC3;
    localparam logic [7:0] I_NOP    = 8'hD0;
    localparam logic [7:0] I_DUMP0  = 8'hE8;
    localparam logic [7:0] I_DUMP1  = 8'hE9;
    localparam logic [7:0] I_DUMP2  = 8'hEA;
    localparam logic [7:0] I_DUMP3  = 8'hEB;
    localparam logic [7:0] I_DUMP4  = 8'hEC;
    localparam logic [7:0] I_FDUMP  = 8'hED;
    localparam logic [7:0] I_DUMP5  = 8'hEF;
    localparam logic [7:0] I_PUTC   = 8'hE0;
    localparam logic [7:0] I_GETC   = 8'hE1;
    localparam logic [7:0] I_PSTR   = 8'hE2;
    localparam logic [7:0] I_EXIT   = 8'hEE;
    localparam logic [3:0] G_PUSH   = 4'h8;
    localparam logic [3:0] G_POP    = 4'h9;

    // Operands gathered for one instruction
    typedef struct packed {
        logic [7:0] oc;
        logic [7:0] n1;
        logic [7:0] n2;
        logic [7:0] n3;
        logic [7:0] va;
        logic [7:0] vb;
        logic [7:0] vr;
        logic [7:0] md;
        logic [7:0] pc;
        logic [7:0] sp;
        logic [7:0] data;
    } exec_in_t;

    // Read selects and state updates of one instruction
    typedef struct packed {
        logic [3:0] ra_idx;
        logic [3:0] rb_idx;
        logic [3:0] rc_idx;
        logic [7:0] maddr;
        logic [2:0] ev;
        logic [7:0] val;
        logic       halt;
        logic [7:0] pc_next;
        logic [7:0] sp_next;
        logic       rf_we;
        logic [3:0] rf_idx;
        logic       rf2_we;
        logic [3:0] rf2_idx;
        logic [7:0] rf_val;
        logic       mem_we;
        logic [7:0] mem_addr;
        logic [7:0] mem_val;
    } exec_out_t;

endpackage

@@ src/bcis_req_if.sv @@
// Request channel: valid/ready with opcode, address and data.
interface bcis_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] address;
    logic [7:0] data;

    modport source (output valid, output opcode, output address, output data, input ready);
    modport sink (input valid, input opcode, input address, input data, output ready);
endinterface

@@ src/bcis_rsp_if.sv @@
// Result channel: valid/ready with event, value and program counter.
interface bcis_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] value;
    logic [7:0] program_counter;

    modport source (output valid, output event_res, output value, output program_counter,
                    input ready);
    modport sink (input valid, input event_res, input value, input program_counter,
                  output ready);
endinterface

@@ src/bcis_ram.sv @@
// Generic single-port RAM with registered read.
module bcis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/bcis_exec.sv @@
// Instruction decode and execute: read selects and all state updates.
module bcis_exec (
    input  bcis_pkg::exec_in_t  ei,
    output bcis_pkg::exec_out_t eo
);
    logic [3:0] a;
    logic [3:0] b;
    logic [2:0] s;
    logic       we1;
    logic       we2;
    logic [3:0] idx1;
    logic [3:0] idx2;
    logic [7:0] wv;
    logic [7:0] adv;
    logic       jmp;
    logic [7:0] target;
    logic       sp_ovr;
    logic [7:0] sp_val;
    logic       stop;
    logic [2:0] stop_ev;
    logic [7:0] pb;
    logic [7:0] sb;
    logic       cond;
    logic [15:0] rotl;
    logic [15:0] rotr;
    logic [11:0] prod;

    assign a    = ei.n1[7:4];
    assign b    = ei.n1[3:0];
    assign s    = ei.vb[2:0];
    assign rotl = {ei.va, ei.va} << s;
    assign rotr = {ei.va, ei.va} >> s;
    assign prod = {8'd0, b} * {4'd0, ei.n2};

    // Read selects depend on opcode and the first operand bytes
    always_comb
    begin
        eo.ra_idx = a;
        eo.rb_idx = b;
        if (ei.oc[7:4] == bcis_pkg::G_PUSH || ei.oc[7:4] == bcis_pkg::G_POP)
        begin
            eo.ra_idx = ei.oc[3:0];
        end
        else if (ei.oc == bcis_pkg::I_ADDST || ei.oc == bcis_pkg::I_SUBST)
        begin
            eo.ra_idx = ei.n2[7:4];
            eo.rb_idx = ei.n2[3:0];
        end
        eo.rc_idx = (ei.oc == bcis_pkg::I_PUTC) ? 4'd1 : 4'd0;
        if (ei.oc == bcis_pkg::I_LD || ei.oc == bcis_pkg::I_MCPY)
        begin
            eo.maddr = ei.vb;
        end
        else if (ei.oc == bcis_pkg::I_ADDM || ei.oc == bcis_pkg::I_SUBM
                 || ei.oc == bcis_pkg::I_RSUBM)
        begin
            eo.maddr = ei.n2;
        end
        else
        begin
            eo.maddr = ei.sp;
        end
    end

    // Execute
    always_comb
    begin
        we1 = 1'b0;
        we2 = 1'b0;
        idx1 = a;
        idx2 = b;
        wv = 8'd0;
        adv = 8'd0;
        jmp = 1'b0;
        target = 8'd0;
        sp_ovr = 1'b0;
        sp_val = ei.sp;
        stop = 1'b0;
        stop_ev = bcis_pkg::EV_INVALID;
        cond = 1'b0;
        eo.ev = bcis_pkg::EV_DONE;
        eo.val = 8'd0;
        eo.mem_we = 1'b0;
        eo.mem_addr = ei.sp;
        eo.mem_val = 8'd0;

        if (ei.oc[7:4] == 4'h0)
        begin
            we1 = 1'b1;
            idx1 = ei.oc[3:0];
            wv = ei.n1;
            adv = (ei.oc[3:0] == bcis_pkg::REG_PC) ? 8'd0 : 8'd2;
        end
        else if (ei.oc[7:4] == bcis_pkg::G_PUSH)
        begin
            if (ei.sp == 8'd0)
            begin
                stop = 1'b1;
                stop_ev = bcis_pkg::EV_STACK;
            end
            else
            begin
                sp_ovr = 1'b1;
                sp_val = ei.sp - 8'd1;
                eo.mem_we = 1'b1;
                eo.mem_addr = ei.sp - 8'd1;
                eo.mem_val = ei.va;
                adv = 8'd1;
            end
        end
        else if (ei.oc[7:4] == bcis_pkg::G_POP)
        begin
            if (ei.sp == 8'hFF)
            begin
                stop = 1'b1;
                stop_ev = bcis_pkg::EV_STACK;
            end
            else
            begin
                we1 = 1'b1;
                idx1 = ei.oc[3:0];
                wv = ei.md;
                sp_ovr = 1'b1;
                sp_val = ((ei.oc[3:0] == bcis_pkg::REG_SP) ? ei.md : ei.sp) + 8'd1;
                adv = (ei.oc[3:0] == bcis_pkg::REG_PC) ? 8'd0 : 8'd1;
            end
        end
        else if (ei.oc >= bcis_pkg::I_JLT && ei.oc <= bcis_pkg::I_JNE)
        begin
            case (ei.oc)
                bcis_pkg::I_JLT: cond = ei.va < ei.vb;
                bcis_pkg::I_JLE: cond = ei.va <= ei.vb;
                bcis_pkg::I_JEQ: cond = ei.va == ei.vb;
                bcis_pkg::I_JGE: cond = ei.va >= ei.vb;
                bcis_pkg::I_JGT: cond = ei.va > ei.vb;
                default:         cond = ei.va != ei.vb;
            endcase
            jmp = cond;
            target = ei.n2;
            adv = 8'd3;
        end
        else
        begin
            case (ei.oc)
                bcis_pkg::I_MOV:   begin we1 = 1'b1; wv = ei.vb; adv = 8'd2; end
                bcis_pkg::I_LD:    begin we1 = 1'b1; wv = ei.md; adv = 8'd2; end
                bcis_pkg::I_ST:
                begin
                    eo.mem_we = 1'b1; eo.mem_addr = ei.va; eo.mem_val = ei.vb; adv = 8'd2;
                end
                bcis_pkg::I_MCPY:
                begin
                    eo.mem_we = 1'b1; eo.mem_addr = ei.va; eo.mem_val = ei.md; adv = 8'd2;
                end
                bcis_pkg::I_LI2:
                begin
                    we1 = 1'b1; we2 = 1'b1; wv = ei.n2; adv = 8'd3;
                end
                bcis_pkg::I_ADDI:  begin we1 = 1'b1; wv = ei.va + {4'd0, b}; adv = 8'd2; end
                bcis_pkg::I_SUBI:  begin we1 = 1'b1; wv = ei.va - {4'd0, b}; adv = 8'd2; end
                bcis_pkg::I_PCADD: begin we1 = 1'b1; wv = ei.pc + {4'd0, b}; adv = 8'd2; end
                bcis_pkg::I_PCSUB: begin we1 = 1'b1; wv = ei.pc - {4'd0, b}; adv = 8'd2; end
                bcis_pkg::I_AND:   begin we1 = 1'b1; wv = ei.va & ei.vb; adv = 8'd2; end
                bcis_pkg::I_OR:    begin we1 = 1'b1; wv = ei.va | ei.vb; adv = 8'd2; end
                bcis_pkg::I_XOR:   begin we1 = 1'b1; wv = ei.va ^ ei.vb; adv = 8'd2; end
                bcis_pkg::I_SHL:   begin we1 = 1'b1; wv = ei.va << s; adv = 8'd2; end
                bcis_pkg::I_SHR:   begin we1 = 1'b1; wv = ei.va >> s; adv = 8'd2; end
                bcis_pkg::I_ROL:   begin we1 = 1'b1; wv = rotl[15:8]; adv = 8'd2; end
                bcis_pkg::I_ROR:   begin we1 = 1'b1; wv = rotr[7:0]; adv = 8'd2; end
                bcis_pkg::I_JMP:   begin jmp = 1'b1; target = ei.n1; end
                bcis_pkg::I_SKNZ:
                    adv = (ei.va != 8'd0) ? ({4'd0, b} + 8'd2) : 8'd2;
                bcis_pkg::I_SKZ:
                    adv = (ei.va == 8'd0) ? ({4'd0, b} + 8'd2) : 8'd2;
                bcis_pkg::I_ADD:   begin we1 = 1'b1; wv = ei.va + ei.vb; adv = 8'd2; end
                bcis_pkg::I_ADDM:  begin we1 = 1'b1; wv = ei.vb + ei.md; adv = 8'd3; end
                bcis_pkg::I_ADDST:
                begin
                    eo.mem_we = 1'b1; eo.mem_addr = ei.n1; eo.mem_val = ei.va + ei.vb;
                    adv = 8'd3;
                end
                bcis_pkg::I_ADDK:  begin we1 = 1'b1; wv = ei.vb + ei.n2; adv = 8'd3; end
                bcis_pkg::I_MULK:  begin we1 = 1'b1; wv = prod[7:0]; adv = 8'd3; end
                bcis_pkg::I_SUMK:  begin we1 = 1'b1; wv = {4'd0, b} + ei.n2; adv = 8'd3; end
                bcis_pkg::I_MACK:  begin we1 = 1'b1; wv = prod[7:0] + ei.n3; adv = 8'd4; end
                bcis_pkg::I_SUB:   begin we1 = 1'b1; wv = ei.va - ei.vb; adv = 8'd2; end
                bcis_pkg::I_SUBM:  begin we1 = 1'b1; wv = ei.vb - ei.md; adv = 8'd3; end
                bcis_pkg::I_RSUBM: begin we1 = 1'b1; wv = ei.md - ei.vb; adv = 8'd3; end
                bcis_pkg::I_SUBST:
                begin
                    eo.mem_we = 1'b1; eo.mem_addr = ei.n1; eo.mem_val = ei.va - ei.vb;
                    adv = 8'd3;
                end
                bcis_pkg::I_SUBK:  begin we1 = 1'b1; wv = ei.vb - ei.n2; adv = 8'd3; end
                bcis_pkg::I_RSUBK: begin we1 = 1'b1; wv = ei.n2 - ei.vb; adv = 8'd3; end
                bcis_pkg::I_CALL:
                begin
                    if (ei.sp == 8'd0)
                    begin
                        stop = 1'b1;
                        stop_ev = bcis_pkg::EV_STACK;
                    end
                    else
                    begin
                        sp_ovr = 1'b1;
                        sp_val = ei.sp - 8'd1;
                        eo.mem_we = 1'b1;
                        eo.mem_addr = ei.sp - 8'd1;
                        eo.mem_val = ei.pc + 8'd2;
                        jmp = 1'b1;
                        target = ei.n1;
                    end
                end
                bcis_pkg::I_RET:
                begin
                    if (ei.sp == 8'hFF)
                    begin
                        stop = 1'b1;
                        stop_ev = bcis_pkg::EV_STACK;
                    end
                    else
                    begin
                        sp_ovr = 1'b1;
                        sp_val = ei.sp + 8'd1;
                        jmp = 1'b1;
                        target = ei.md;
                    end
                end
                bcis_pkg::I_NOP, bcis_pkg::I_DUMP0, bcis_pkg::I_DUMP1, bcis_pkg::I_DUMP2,
                bcis_pkg::I_DUMP3, bcis_pkg::I_DUMP4, bcis_pkg::I_DUMP5:
                    adv = 8'd1;
                bcis_pkg::I_FDUMP: adv = 8'd2;
                bcis_pkg::I_PUTC:
                begin
                    eo.ev = bcis_pkg::EV_CHAR;
                    eo.val = ei.vr;
                    adv = 8'd1;
                end
                bcis_pkg::I_GETC:
                begin
                    we1 = 1'b1; idx1 = 4'd0; wv = ei.data; adv = 8'd1;
                end
                bcis_pkg::I_EXIT:
                begin
                    stop = 1'b1;
                    stop_ev = bcis_pkg::EV_EXIT;
                end
                default:
                begin
                    stop = 1'b1;
                    stop_ev = bcis_pkg::EV_INVALID;
                end
            endcase
        end

        // Register writes to pc or sp land before the advance
        pb = ei.pc;
        sb = ei.sp;
        if (we1 && idx1 == bcis_pkg::REG_PC) pb = wv;
        if (we2 && idx2 == bcis_pkg::REG_PC) pb = wv;
        if (we1 && idx1 == bcis_pkg::REG_SP) sb = wv;
        if (we2 && idx2 == bcis_pkg::REG_SP) sb = wv;

        eo.halt = stop;
        if (stop)
        begin
            eo.ev = stop_ev;
            eo.val = ei.vr;
            eo.pc_next = ei.pc;
            eo.sp_next = ei.sp;
            eo.rf_we = 1'b0;
            eo.rf2_we = 1'b0;
            eo.mem_we = 1'b0;
        end
        else
        begin
            eo.pc_next = jmp ? target : pb + adv;
            eo.sp_next = sp_ovr ? sp_val : sb;
            eo.rf_we = we1 && (idx1 < bcis_pkg::REG_SP);
            eo.rf2_we = we2 && (idx2 < bcis_pkg::REG_SP);
        end
        eo.rf_idx = idx1;
        eo.rf2_idx = idx2;
        eo.rf_val = wv;
    end
endmodule

@@ src/byte_cpu_instruction_step.sv @@
// Byte CPU top level: request sequencer around memory and register file RAMs.
// Path: write, start, halted and unused requests go IDLE, DONE; a step goes
// F1-F4, R1-R3, M1, EX, WR2 (LI2 only), DONE; a string step F1, F2, DONE.
// Throughput: one request at a time, set by the single-port memory and
// register-file RAM accesses; a new request is taken while a result waits.
// Reset: CPU halted, all memory and registers read as zero, string mode off.
`include "byte_cpu_instruction_step_defines.svh"

module byte_cpu_instruction_step #(
    parameter int MEM_BYTES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata,
    bcis_req_if.sink       req,
    bcis_rsp_if.source     rsp
);
    localparam int AW = $clog2(MEM_BYTES);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_F1   = 4'd1;
    localparam logic [3:0] ST_F2   = 4'd2;
    localparam logic [3:0] ST_F3   = 4'd3;
    localparam logic [3:0] ST_F4   = 4'd4;
    localparam logic [3:0] ST_R1   = 4'd5;
    localparam logic [3:0] ST_R2   = 4'd6;
    localparam logic [3:0] ST_R3   = 4'd7;
    localparam logic [3:0] ST_M1   = 4'd8;
    localparam logic [3:0] ST_EX   = 4'd9;
    localparam logic [3:0] ST_WR2  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  start_reg;
    logic [7:0]  pc_reg, sp_reg;
    logic        halted_reg, str_reg;
    logic [MEM_BYTES-1:0] mem_vld_reg;
    logic [15:0] rf_vld_reg;
    logic        mem_q_vld_reg, rf_q_vld_reg;
    logic [3:0]  rf_q_idx_reg;
    logic [7:0]  oc_reg, n1_reg, n2_reg, n3_reg, va_reg, vb_reg, vr_reg, md_reg, data_reg;
    logic [2:0]  ev_reg;
    logic [7:0]  val_reg;
    logic        rf2_we_reg;
    logic [3:0]  rf2_idx_reg;
    logic [7:0]  rf2_val_reg;
    logic        out_vld_reg;
    logic [2:0]  out_ev_reg;
    logic [7:0]  out_val_reg, out_pc_reg;

    logic          accept;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata, mq;
    logic          rf_we;
    logic [3:0]    rf_addr;
    logic [7:0]    rf_wdata, rf_rdata, rq;
    logic          mem_rd;
    logic          rf_rd;
    logic          pstr;

    bcis_pkg::exec_in_t  ei;
    bcis_pkg::exec_out_t eo;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign mq = mem_q_vld_reg ? mem_rdata : 8'd0;
    assign rq = (rf_q_idx_reg == bcis_pkg::REG_SP) ? sp_reg :
                (rf_q_idx_reg == bcis_pkg::REG_PC) ? pc_reg :
                rf_q_vld_reg ? rf_rdata : 8'd0;
    assign pstr = str_reg || (oc_reg == bcis_pkg::I_PSTR);

    // Operands to the execute unit
    always_comb
    begin
        ei.oc = oc_reg;
        ei.n1 = n1_reg;
        ei.n2 = n2_reg;
        ei.n3 = n3_reg;
        ei.va = va_reg;
        ei.vb = vb_reg;
        ei.vr = vr_reg;
        ei.md = md_reg;
        ei.pc = pc_reg;
        ei.sp = sp_reg;
        ei.data = data_reg;
    end

    bcis_exec u_exec (
        .ei (ei),
        .eo (eo)
    );

    // Memory port select
    always_comb
    begin
        mem_we = 1'b0;
        mem_rd = 1'b0;
        mem_addr = AW'(pc_reg);
        mem_wdata = req.data;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.opcode == bcis_pkg::REQ_WRITE)
                begin
                    mem_we = 1'b1;
                    mem_addr = AW'(req.address);
                end
                else if (accept && req.opcode == bcis_pkg::REQ_START)
                begin
                    mem_we = 1'b1;
                    mem_addr = AW'(MEM_BYTES - 1);
                    mem_wdata = start_reg;
                end
                else
                begin
                    mem_rd = 1'b1;
                end
            end
            ST_F1: begin mem_rd = 1'b1; mem_addr = AW'(pc_reg + 8'd1); end
            ST_F2: begin mem_rd = 1'b1; mem_addr = AW'(pc_reg + 8'd2); end
            ST_F3: begin mem_rd = 1'b1; mem_addr = AW'(pc_reg + 8'd3); end
            ST_R3: begin mem_rd = 1'b1; mem_addr = AW'(eo.maddr); end
            ST_EX:
            begin
                mem_we = eo.mem_we;
                mem_addr = AW'(eo.mem_addr);
                mem_wdata = eo.mem_val;
            end
            default: mem_rd = 1'b0;
        endcase
    end

    // Register file port select
    always_comb
    begin
        rf_we = 1'b0;
        rf_rd = 1'b0;
        rf_addr = eo.ra_idx;
        rf_wdata = eo.rf_val;
        case (state_reg)
            ST_F4: rf_rd = 1'b1;
            ST_R1: begin rf_rd = 1'b1; rf_addr = eo.rb_idx; end
            ST_R2: begin rf_rd = 1'b1; rf_addr = eo.rc_idx; end
            ST_EX: begin rf_we = eo.rf_we; rf_addr = eo.rf_idx; end
            ST_WR2:
            begin
                rf_we = rf2_we_reg;
                rf_addr = rf2_idx_reg;
                rf_wdata = rf2_val_reg;
            end
            default: rf_rd = 1'b0;
        endcase
    end

    bcis_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bcis_ram #(.WIDTH(8), .DEPTH(16)) u_rf (
        .clk   (clk),
        .we    (rf_we),
        .addr  (rf_addr),
        .wdata (rf_wdata),
        .rdata (rf_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == bcis_pkg::REQ_STEP && !halted_reg)
                    begin
                        state_next = ST_F1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = pstr ? ST_DONE : ST_F3;
            ST_F3:   state_next = ST_F4;
            ST_F4:   state_next = ST_R1;
            ST_R1:   state_next = ST_R2;
            ST_R2:   state_next = ST_R3;
            ST_R3:   state_next = ST_M1;
            ST_M1:   state_next = ST_EX;
            ST_EX:   state_next = eo.rf2_we ? ST_WR2 : ST_DONE;
            ST_WR2:  state_next = ST_DONE;
            ST_DONE: state_next = (!out_vld_reg || rsp.ready) ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 8'd0;
            pc_reg <= 8'd0;
            sp_reg <= 8'd0;
            halted_reg <= 1'b1;
            str_reg <= 1'b0;
            mem_vld_reg <= '0;
            rf_vld_reg <= '0;
            mem_q_vld_reg <= 1'b0;
            rf_q_vld_reg <= 1'b0;
            rf_q_idx_reg <= 4'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
            if (mem_we)
            begin
                mem_vld_reg[mem_addr] <= 1'b1;
            end
            if (rf_we)
            begin
                rf_vld_reg[rf_addr] <= 1'b1;
            end
            if (mem_rd)
            begin
                mem_q_vld_reg <= mem_vld_reg[mem_addr];
            end
            if (rf_rd)
            begin
                rf_q_vld_reg <= rf_vld_reg[rf_addr];
                rf_q_idx_reg <= rf_addr;
            end
            if (accept && req.opcode == bcis_pkg::REQ_START)
            begin
                pc_reg <= start_reg;
                sp_reg <= 8'(MEM_BYTES - 1);
                halted_reg <= 1'b0;
                str_reg <= 1'b0;
            end
            if (state_reg == ST_F2 && pstr)
            begin
                str_reg <= (mq != 8'd0);
                pc_reg <= pc_reg + ((mq != 8'd0) ? 8'd1 : 8'd2);
            end
            if (state_reg == ST_EX)
            begin
                pc_reg <= eo.pc_next;
                sp_reg <= eo.sp_next;
                if (eo.halt)
                begin
                    halted_reg <= 1'b1;
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && (!out_vld_reg || rsp.ready))
            begin
                out_vld_reg <= 1'b1;
            end
        end
    end

    // Operand and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= req.data;
            ev_reg <= (req.opcode == bcis_pkg::REQ_STEP && halted_reg) ?
                      bcis_pkg::EV_HALTED : bcis_pkg::EV_NONE;
            val_reg <= 8'd0;
        end
        if (state_reg == ST_F1) oc_reg <= mq;
        if (state_reg == ST_F2)
        begin
            n1_reg <= mq;
            if (pstr)
            begin
                ev_reg <= (mq != 8'd0) ? bcis_pkg::EV_CHAR : bcis_pkg::EV_DONE;
                val_reg <= mq;
            end
        end
        if (state_reg == ST_F3) n2_reg <= mq;
        if (state_reg == ST_F4) n3_reg <= mq;
        if (state_reg == ST_R1) va_reg <= rq;
        if (state_reg == ST_R2) vb_reg <= rq;
        if (state_reg == ST_R3) vr_reg <= rq;
        if (state_reg == ST_M1) md_reg <= mq;
        if (state_reg == ST_EX)
        begin
            ev_reg <= eo.ev;
            val_reg <= eo.val;
            rf2_we_reg <= eo.rf2_we;
            rf2_idx_reg <= eo.rf2_idx;
            rf2_val_reg <= eo.rf_val;
        end
        if (state_reg == ST_DONE && (!out_vld_reg || rsp.ready))
        begin
            out_ev_reg <= ev_reg;
            out_val_reg <= (ev_reg == bcis_pkg::EV_DONE) ? 8'd0 : val_reg;
            out_pc_reg <= pc_reg;
        end
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.event_res = out_ev_reg;
    assign rsp.value = out_val_reg;
    assign rsp.program_counter = out_pc_reg;

    // Checks
    `BCIS_ASSERT_NEXT(a_start_runs, accept && req.opcode == bcis_pkg::REQ_START, !halted_reg && sp_reg == 8'(MEM_BYTES - 1))
    `BCIS_ASSERT_NEXT(a_fault_halts, state_reg == ST_EX && eo.halt, halted_reg)
    `BCIS_ASSERT_SAME(a_rf_low_only, rf_we, rf_addr != bcis_pkg::REG_SP && rf_addr != bcis_pkg::REG_PC)
    `BCIS_ASSERT_SAME(a_one_port_op, mem_we, !mem_rd)
endmodule
